[hdl/pds_pkg.sv]
// Package with the shared types, constants and helper functions of the disc splatter.
`timescale 1ns / 1ps
package pds_pkg;

	localparam int MaxImageSize = 1024;
	localparam int SizeW        = 11;
	localparam int PixW         = 10;
	localparam int GrayW        = 16;
	localparam int DivRemW      = 32;
	localparam int DivLoW       = 25;
	localparam int DivCntW      = 5;
	localparam int FifoDepth    = 4;
	localparam int FifoAw       = 2;
	localparam int FifoCntW     = 3;

	localparam logic [GrayW-1:0] WhiteGray   = 16'd65529;
	localparam logic [GrayW-1:0] SatGray     = 16'd65535;
	localparam logic [8:0]       ColorOffset = 9'd10;

	// Steps the shared divider runs for each kind of quotient.
	localparam logic [DivCntW-1:0] StepsPos  = 5'd10;
	localparam logic [DivCntW-1:0] StepsMod  = 5'd20;
	localparam logic [DivCntW-1:0] StepsGray = 5'd25;

	typedef enum logic [2:0] {
		REG_HALF_WIDTH = 3'd0,
		REG_IMAGE_SIZE = 3'd1,
		REG_POINT_SIZE = 3'd2,
		REG_AXIS       = 3'd3,
		REG_COLOR_LOW  = 3'd4,
		REG_COLOR_HIGH = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		AXIS_NONE = 2'd0,
		AXIS_X    = 2'd1,
		AXIS_Y    = 2'd2,
		AXIS_Z    = 2'd3
	} axis_t;

	typedef struct packed {
		logic [30:0]      half_width;
		logic [SizeW-1:0] image_size;
		logic [2:0]       point_size;
		logic [1:0]       axis;
		logic [7:0]       color_low;
		logic [7:0]       color_high;
	} cfg_t;

	// One classified star waiting for the disc rasterizer.
	typedef struct packed {
		logic [PixW-1:0]  px;
		logic [PixW-1:0]  py;
		logic [GrayW-1:0] gray;
	} item_t;

	typedef struct packed {
		logic [DivRemW-1:0] rem_init;
		logic [DivLoW-1:0]  lo;
		logic [DivRemW-1:0] divisor;
		logic [DivCntW-1:0] steps;
	} div_req_t;

	// Image size limited to the largest supported image.
	function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] s);
		logic [SizeW-1:0] r;
		r = (s > SizeW'(MaxImageSize)) ? SizeW'(MaxImageSize) : s;
		return r;
	endfunction

	// Half-width of one disc row at distance a from the center row.
	function automatic logic [1:0] row_half(input logic [1:0] r, input logic [1:0] a);
		logic [1:0] h;
		h = r;
		if (r == 2'd2) begin
			h = (a == 2'd2) ? 2'd1 : 2'd2;
		end else if (r == 2'd3) begin
			case (a)
				2'd0: h = 2'd3;
				2'd1: h = 2'd3;
				2'd2: h = 2'd2;
				default: h = 2'd1;
			endcase
		end
		return h;
	endfunction

endpackage

[hdl/pds_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the front end.
`timescale 1ns / 1ps
module pds_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  pds_pkg::div_req_t         req,
	output logic                      done,
	output logic [pds_pkg::DivLoW-1:0]  quot,
	output logic [pds_pkg::DivRemW-1:0] rem
);

	logic [pds_pkg::DivRemW-1:0] rem_q;
	logic [pds_pkg::DivLoW-1:0]  lo_q;
	logic [pds_pkg::DivLoW-1:0]  quot_q;
	logic [pds_pkg::DivRemW-1:0] div_q;
	logic [pds_pkg::DivCntW-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [pds_pkg::DivRemW:0]   trial;
	logic [pds_pkg::DivRemW:0]   diff;
	logic                        ge;

	// Bring down the next dividend bit and try one subtraction.
	always_comb begin
		trial = {rem_q, lo_q[pds_pkg::DivLoW-1]};
		diff  = trial - {1'b0, div_q};
		ge    = (trial >= {1'b0, div_q});
	end

	// Step counter and status flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= req.steps;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == pds_pkg::DivCntW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder, dividend bits and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= req.rem_init;
			lo_q   <= req.lo;
			div_q  <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[pds_pkg::DivRemW-1:0] : trial[pds_pkg::DivRemW-1:0];
			lo_q   <= {lo_q[pds_pkg::DivLoW-2:0], 1'b0};
			quot_q <= {quot_q[pds_pkg::DivLoW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

[hdl/pds_front.sv]
// Front end: takes a star, culls it, and works out its pixel and gray level.
`timescale 1ns / 1ps
module pds_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pds_pkg::cfg_t          cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [31:0]     pos_x,
	input  logic signed [31:0]     pos_y,
	input  logic signed [31:0]     pos_z,
	input  logic signed [19:0]     star_index,
	input  logic                   fifo_full,
	output logic                   push,
	output pds_pkg::item_t         push_item
);

	typedef enum logic [10:0] {
		F_IDLE = 11'b00000000001,
		F_CHK  = 11'b00000000010,
		F_LI   = 11'b00000000100,
		F_WI   = 11'b00000001000,
		F_LJ   = 11'b00000010000,
		F_WJ   = 11'b00000100000,
		F_LM   = 11'b00001000000,
		F_WM   = 11'b00010000000,
		F_LG   = 11'b00100000000,
		F_WG   = 11'b01000000000,
		F_PUSH = 11'b10000000000
	} fstate_t;

	fstate_t state_q;

	logic signed [31:0] u_q;
	logic signed [31:0] v_q;
	logic signed [19:0] idx_q;
	logic [41:0]        nu_q;
	logic [41:0]        nv_q;
	logic [pds_pkg::PixW-1:0]  pi_q;
	logic [pds_pkg::PixW-1:0]  pj_q;
	logic [7:0]                m_q;
	logic [pds_pkg::GrayW-1:0] gray_q;

	logic [pds_pkg::SizeW-1:0] size_eff;
	logic signed [32:0]        lim;
	logic signed [32:0]        u_ext;
	logic signed [32:0]        v_ext;
	logic                      in_view;
	logic [32:0]               au;
	logic [32:0]               av;
	logic [43:0]               prod_u;
	logic [43:0]               prod_v;
	logic [8:0]                m_off;

	logic                        div_start;
	pds_pkg::div_req_t           div_req;
	logic                        div_done;
	logic [pds_pkg::DivLoW-1:0]  div_quot;
	logic [pds_pkg::DivRemW-1:0] div_rem;

	// Window test and the numerators of the pixel coordinates.
	always_comb begin
		size_eff = pds_pkg::eff_size(cfg.image_size);
		lim      = $signed({2'b00, cfg.half_width});
		u_ext    = 33'(u_q);
		v_ext    = 33'(v_q);
		in_view  = (u_ext > -lim) && (u_ext < lim) && (v_ext > -lim) && (v_ext < lim);
		au       = 33'({2'b00, cfg.half_width}) + 33'(u_q);
		av       = 33'({2'b00, cfg.half_width}) + 33'(v_q);
		prod_u   = au[31:0] * {1'b0, size_eff[10:0]};
		prod_v   = av[31:0] * {1'b0, size_eff[10:0]};
		m_off    = {1'b0, m_q} + pds_pkg::ColorOffset;
	end

	// Operands for the shared divider.
	always_comb begin
		div_start = (state_q == F_LI) || (state_q == F_LJ) ||
			(state_q == F_LM) || (state_q == F_LG);
		div_req.rem_init = nu_q[41:10];
		div_req.lo       = {nu_q[9:0], 15'b0};
		div_req.divisor  = {cfg.half_width, 1'b0};
		div_req.steps    = pds_pkg::StepsPos;
		case (state_q)
			F_LJ: begin
				div_req.rem_init = nv_q[41:10];
				div_req.lo       = {nv_q[9:0], 15'b0};
			end
			F_LM: begin
				div_req.rem_init = '0;
				div_req.lo       = {idx_q, 5'b0};
				div_req.divisor  = 32'(cfg.color_high - cfg.color_low);
				div_req.steps    = pds_pkg::StepsMod;
			end
			F_LG: begin
				div_req.rem_init = '0;
				div_req.lo       = {m_off, 16'b0};
				div_req.divisor  = 32'(cfg.color_high);
				div_req.steps    = pds_pkg::StepsGray;
			end
			default: begin
				div_req.steps = pds_pkg::StepsPos;
			end
		endcase
	end

	pds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// Sequencer for one star.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: if (in_valid) state_q <= F_CHK;
				F_CHK: begin
					if (in_view && (size_eff != '0)) state_q <= F_LI;
					else state_q <= F_IDLE;
				end
				F_LI: state_q <= F_WI;
				F_WI: if (div_done) state_q <= F_LJ;
				F_LJ: state_q <= F_WJ;
				F_WJ: begin
					if (div_done) begin
						if ((idx_q <= 0) || (cfg.color_high == '0)) state_q <= F_PUSH;
						else if (cfg.color_high > cfg.color_low) state_q <= F_LM;
						else state_q <= F_LG;
					end
				end
				F_LM: state_q <= F_WM;
				F_WM: if (div_done) state_q <= F_LG;
				F_LG: state_q <= F_WG;
				F_WG: if (div_done) state_q <= F_PUSH;
				F_PUSH: if (!fifo_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Star data and intermediate results.
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					case (pds_pkg::axis_t'(cfg.axis))
						pds_pkg::AXIS_X: begin
							u_q <= pos_y;
							v_q <= pos_z;
						end
						pds_pkg::AXIS_Y: begin
							u_q <= pos_z;
							v_q <= pos_x;
						end
						default: begin
							u_q <= pos_x;
							v_q <= pos_y;
						end
					endcase
					idx_q <= star_index;
				end
			end
			F_CHK: begin
				nu_q <= prod_u[41:0];
				nv_q <= prod_v[41:0];
			end
			F_WI: if (div_done) pi_q <= div_quot[pds_pkg::PixW-1:0];
			F_WJ: begin
				if (div_done) begin
					pj_q <= div_quot[pds_pkg::PixW-1:0];
					m_q  <= '0;
					if (idx_q <= 0) gray_q <= pds_pkg::WhiteGray;
					else gray_q <= pds_pkg::SatGray;
				end
			end
			F_WM: if (div_done) m_q <= div_rem[7:0];
			F_WG: begin
				if (div_done) begin
					if (div_quot[24:16] != '0) gray_q <= pds_pkg::SatGray;
					else gray_q <= div_quot[15:0];
				end
			end
			default: begin
				gray_q <= gray_q;
			end
		endcase
	end

	assign in_ready       = (state_q == F_IDLE);
	assign push           = (state_q == F_PUSH) && !fifo_full;
	assign push_item.px   = pi_q;
	assign push_item.py   = pj_q;
	assign push_item.gray = gray_q;

endmodule

[hdl/pds_fifo.sv]
// Short queue of classified stars between the front end and the rasterizer.
`timescale 1ns / 1ps
module pds_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pds_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output pds_pkg::item_t head_item,
	output logic           empty
);

	pds_pkg::item_t mem_q [pds_pkg::FifoDepth];
	logic [pds_pkg::FifoAw-1:0]   wr_q;
	logic [pds_pkg::FifoAw-1:0]   rd_q;
	logic [pds_pkg::FifoCntW-1:0] cnt_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	assign head_item = mem_q[rd_q];
	assign full      = (cnt_q == pds_pkg::FifoCntW'(pds_pkg::FifoDepth));
	assign empty     = (cnt_q == '0);

endmodule

[hdl/pds_back.sv]
// Back end: walks a star's clipped disc, one pixel write per cycle unless stalled.
`timescale 1ns / 1ps
module pds_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pds_pkg::cfg_t                     cfg,
	input  logic                              fifo_empty,
	input  pds_pkg::item_t                    head_item,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pds_pkg::PixW-1:0]          pixel_x,
	output logic [pds_pkg::PixW-1:0]          pixel_y,
	output logic [pds_pkg::GrayW-1:0]         gray_level,
	output logic                              last_pixel
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_RUN  = 2'b10
	} bstate_t;

	typedef logic signed [2:0] off_t;

	bstate_t state_q;

	logic [pds_pkg::PixW-1:0]  pi_q;
	logic [pds_pkg::PixW-1:0]  pj_q;
	logic [pds_pkg::GrayW-1:0] gray_q;
	logic [1:0]                r_q;
	off_t                      ii_q;
	off_t                      jj_q;
	off_t                      ihi_q;
	off_t                      jlo_q;
	off_t                      jhi_q;

	logic                        out_valid_q;
	logic [pds_pkg::PixW-1:0]    px_q;
	logic [pds_pkg::PixW-1:0]    py_q;
	logic [pds_pkg::GrayW-1:0]   gr_q;
	logic                        last_q;

	logic [pds_pkg::SizeW-1:0] size_eff;
	logic [1:0]                r_new;
	logic [pds_pkg::SizeW-1:0] di;
	logic [pds_pkg::SizeW-1:0] dj;
	off_t                      ilo_new;
	off_t                      ihi_new;
	off_t                      jlo_new;
	off_t                      jhi_new;
	off_t                      jend;
	off_t                      ii_next;
	logic                      adv;
	logic                      last_now;

	// First column of a disc row, after clipping.
	function automatic off_t row_start(input off_t ii, input off_t jlo, input logic [1:0] r);
		logic [1:0] a;
		off_t       nh;
		a  = ii[2] ? 2'(-ii) : ii[1:0];
		nh = -$signed({1'b0, pds_pkg::row_half(r, a)});
		return (jlo > nh) ? jlo : nh;
	endfunction

	// Last column of a disc row, after clipping.
	function automatic off_t row_end(input off_t ii, input off_t jhi, input logic [1:0] r);
		logic [1:0] a;
		off_t       h;
		a = ii[2] ? 2'(-ii) : ii[1:0];
		h = $signed({1'b0, pds_pkg::row_half(r, a)});
		return (jhi < h) ? jhi : h;
	endfunction

	// Clip bounds of the star at the head of the queue.
	always_comb begin
		size_eff = pds_pkg::eff_size(cfg.image_size);
		r_new    = cfg.point_size[2:1];
		di       = size_eff - 1'b1 - {1'b0, head_item.px};
		dj       = size_eff - 1'b1 - {1'b0, head_item.py};
		ilo_new  = -$signed({1'b0, (head_item.px < {8'b0, r_new}) ? head_item.px[1:0] : r_new});
		jlo_new  = -$signed({1'b0, (head_item.py < {8'b0, r_new}) ? head_item.py[1:0] : r_new});
		ihi_new  = $signed({1'b0, (di < {9'b0, r_new}) ? di[1:0] : r_new});
		jhi_new  = $signed({1'b0, (dj < {9'b0, r_new}) ? dj[1:0] : r_new});
	end

	// Walk control.
	always_comb begin
		adv      = !out_valid_q || out_ready;
		jend     = row_end(ii_q, jhi_q, r_q);
		ii_next  = ii_q + 3'sd1;
		last_now = (ii_q == ihi_q) && (jj_q == jend);
		pop      = (state_q == B_IDLE) && !fifo_empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				B_IDLE: if (!fifo_empty) state_q <= B_RUN;
				B_RUN: if (adv && last_now) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
			if ((state_q == B_RUN) && adv) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Star bounds, walk position and the output register.
	always_ff @(posedge clk) begin
		if (pop) begin
			pi_q   <= head_item.px;
			pj_q   <= head_item.py;
			gray_q <= head_item.gray;
			r_q    <= r_new;
			ihi_q  <= ihi_new;
			jlo_q  <= jlo_new;
			jhi_q  <= jhi_new;
			ii_q   <= ilo_new;
			jj_q   <= row_start(ilo_new, jlo_new, r_new);
		end else if ((state_q == B_RUN) && adv) begin
			px_q   <= pi_q + {{7{ii_q[2]}}, ii_q};
			py_q   <= pj_q + {{7{jj_q[2]}}, jj_q};
			gr_q   <= gray_q;
			last_q <= last_now;
			if (jj_q == jend) begin
				ii_q <= ii_next;
				jj_q <= row_start(ii_next, jlo_q, r_q);
			end else begin
				jj_q <= jj_q + 3'sd1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_x    = px_q;
	assign pixel_y    = py_q;
	assign gray_level = gr_q;
	assign last_pixel = last_q;

endmodule

[hdl/point_disc_splatter_core.sv]
// Top level of the point disc splatter: configuration registers and the three stages.
`timescale 1ns / 1ps
// Each accepted star is projected along the chosen axis, culled against the open view
// square, and turned into a pixel position and a gray level by one shared restoring
// divider that produces one quotient bit per cycle: first the two pixel coordinates,
// then, for a star with a positive index and a nonzero color_high, the color index
// modulo (only when color_high exceeds color_low) and the gray quotient. The front end
// waits to push while the queue is full. Culled stars free the input straight after
// the window check. A four-entry queue feeds the rasterizer, which takes a star off
// the queue and then writes its clipped disc (up to 9 pixels for a full square, 21 or
// 37 for the larger discs) at one pixel per cycle while out_ready allows, while the front
// end can already work on the next stars.
module point_disc_splatter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_addr,
	input  logic [30:0]                       cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [31:0]                pos_x,
	input  logic signed [31:0]                pos_y,
	input  logic signed [31:0]                pos_z,
	input  logic signed [19:0]                star_index,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pds_pkg::PixW-1:0]          pixel_x,
	output logic [pds_pkg::PixW-1:0]          pixel_y,
	output logic [pds_pkg::GrayW-1:0]         gray_level,
	output logic                              last_pixel
);

	pds_pkg::cfg_t  cfg_q;
	logic           push;
	pds_pkg::item_t push_item;
	logic           fifo_full;
	logic           pop;
	pds_pkg::item_t head_item;
	logic           fifo_empty;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_width <= 31'd131072;
			cfg_q.image_size <= 11'd256;
			cfg_q.point_size <= 3'd3;
			cfg_q.axis       <= 2'd3;
			cfg_q.color_low  <= 8'd10;
			cfg_q.color_high <= 8'd255;
		end else if (cfg_we) begin
			case (pds_pkg::reg_idx_t'(cfg_addr))
				pds_pkg::REG_HALF_WIDTH: cfg_q.half_width <= cfg_wdata;
				pds_pkg::REG_IMAGE_SIZE: cfg_q.image_size <= cfg_wdata[10:0];
				pds_pkg::REG_POINT_SIZE: cfg_q.point_size <= cfg_wdata[2:0];
				pds_pkg::REG_AXIS:       cfg_q.axis       <= cfg_wdata[1:0];
				pds_pkg::REG_COLOR_LOW:  cfg_q.color_low  <= cfg_wdata[7:0];
				pds_pkg::REG_COLOR_HIGH: cfg_q.color_high <= cfg_wdata[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	pds_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.star_index (star_index),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_item  (push_item)
	);

	pds_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (fifo_full),
		.pop       (pop),
		.head_item (head_item),
		.empty     (fifo_empty)
	);

	pds_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.fifo_empty (fifo_empty),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.gray_level (gray_level),
		.last_pixel (last_pixel)
	);

endmodule

[verif/testbench.sv]
// Self-checking testbench for the point disc splatter core.
`timescale 1ns / 1ps
module testbench;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [2:0]                cfg_addr;
	logic [30:0]               cfg_wdata;
	logic                      in_valid;
	logic                      in_ready;
	logic signed [31:0]        pos_x;
	logic signed [31:0]        pos_y;
	logic signed [31:0]        pos_z;
	logic signed [19:0]        star_index;
	logic                      out_valid;
	logic                      out_ready;
	logic [pds_pkg::PixW-1:0]  pixel_x;
	logic [pds_pkg::PixW-1:0]  pixel_y;
	logic [pds_pkg::GrayW-1:0] gray_level;
	logic                      last_pixel;

	point_disc_splatter_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .star_index(star_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .gray_level(gray_level),
		.last_pixel(last_pixel)
	);

	// One expected pixel write.
	typedef struct {
		logic [pds_pkg::PixW-1:0]  px;
		logic [pds_pkg::PixW-1:0]  py;
		logic [pds_pkg::GrayW-1:0] gray;
		logic                      last;
	} pixel_write_t;

	// One directed star; typed_gray is used only where has_gray is set.
	typedef struct {
		logic signed [31:0]        x;
		logic signed [31:0]        y;
		logic signed [31:0]        z;
		logic signed [19:0]        idx;
		bit                        has_gray;
		logic [pds_pkg::GrayW-1:0] typed_gray;
	} star_row_t;

	localparam int SettleCycles = 150;
	localparam int WatchdogLimit = 5000;
	localparam int NumDirected = 14;

	pixel_write_t pixel_q[$];
	int           fail_count;
	int           idle_cycles;

	// Local copy of the configuration registers.
	logic [30:0]               m_half_width;
	logic [pds_pkg::SizeW-1:0] m_image_size;
	logic [2:0]                m_point_size;
	logic [1:0]                m_axis;
	logic [7:0]                m_color_low;
	logic [7:0]                m_color_high;

	star_row_t directed_stars[NumDirected];

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gray level of a star from its index.
	function automatic logic [pds_pkg::GrayW-1:0] star_gray(input logic signed [19:0] idx);
		longint span;
		longint m;
		longint q;
		m = 0;
		if (idx <= 0) return pds_pkg::WhiteGray;
		span = longint'(m_color_high) - longint'(m_color_low);
		if (span > 0) m = longint'(idx) % span;
		if (m_color_high == 0) return pds_pkg::SatGray;
		q = ((m + 10) << 16) / longint'(m_color_high);
		return (q > 65535) ? pds_pkg::SatGray : pds_pkg::GrayW'(q);
	endfunction

	// Queue the pixel writes that one star should produce.
	task automatic splat_star(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z, input logic signed [19:0] idx,
			input bit has_gray, input logic [pds_pkg::GrayW-1:0] typed_gray);
		longint u, v, l, sz, pi, pj, r, ilo, ihi, jlo, jhi, ii, jj;
		logic [pds_pkg::GrayW-1:0] gray;
		pixel_write_t w;
		int n;
		n = 0;
		if (m_axis == pds_pkg::AXIS_X) begin
			u = y; v = z;
		end else if (m_axis == pds_pkg::AXIS_Y) begin
			u = z; v = x;
		end else begin
			u = x; v = y;
		end
		l = longint'(m_half_width);
		if (!(u > -l && u < l && v > -l && v < l)) return;
		sz = (m_image_size > pds_pkg::MaxImageSize) ? pds_pkg::MaxImageSize
			: longint'(m_image_size);
		if (sz == 0) return;
		pi = ((l + u) * sz) / (2 * l);
		pj = ((l + v) * sz) / (2 * l);
		gray = has_gray ? typed_gray : star_gray(idx);
		r = longint'(m_point_size >> 1);
		if (r > 3) r = 3;
		ilo = (-pi > -r) ? -pi : -r;
		ihi = (sz - 1 - pi < r) ? sz - 1 - pi : r;
		jlo = (-pj > -r) ? -pj : -r;
		jhi = (sz - 1 - pj < r) ? sz - 1 - pj : r;
		for (ii = ilo; ii <= ihi; ii++) begin
			for (jj = jlo; jj <= jhi; jj++) begin
				if (r < 2 || ii * ii + jj * jj <= r * r + r) begin
					w.px = pds_pkg::PixW'(pi + ii);
					w.py = pds_pkg::PixW'(pj + jj);
					w.gray = gray;
					w.last = 1'b0;
					pixel_q.push_back(w);
					n++;
				end
			end
		end
		if (n > 0) pixel_q[pixel_q.size() - 1].last = 1'b1;
	endtask

	// Write one register while the block is idle and mirror it locally.
	task automatic write_reg(input pds_pkg::reg_idx_t idx, input logic [30:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pds_pkg::REG_HALF_WIDTH: m_half_width = value;
			pds_pkg::REG_IMAGE_SIZE: m_image_size = value[pds_pkg::SizeW-1:0];
			pds_pkg::REG_POINT_SIZE: m_point_size = value[2:0];
			pds_pkg::REG_AXIS:       m_axis = value[1:0];
			pds_pkg::REG_COLOR_LOW:  m_color_low = value[7:0];
			pds_pkg::REG_COLOR_HIGH: m_color_high = value[7:0];
			default: ;
		endcase
	endtask

	// Drain the block, then load a full set of registers with junk in unused bits.
	task automatic load_settings(input logic [30:0] hw, input int sz, input int ps,
			input int ax, input int lo, input int hi);
		in_valid <= 1'b0;
		wait (pixel_q.size() == 0);
		repeat (SettleCycles) @(posedge clk);
		write_reg(pds_pkg::REG_HALF_WIDTH, hw);
		write_reg(pds_pkg::REG_IMAGE_SIZE, 31'({$urandom} << pds_pkg::SizeW) | 31'(sz));
		write_reg(pds_pkg::REG_POINT_SIZE, 31'({$urandom} << 3) | 31'(ps));
		write_reg(pds_pkg::REG_AXIS, 31'({$urandom} << 2) | 31'(ax));
		write_reg(pds_pkg::REG_COLOR_LOW, 31'({$urandom} << 8) | 31'(lo));
		write_reg(pds_pkg::REG_COLOR_HIGH, 31'({$urandom} << 8) | 31'(hi));
	endtask

	// Gap length: none half the time, otherwise mostly short and now and then long.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Coordinate mostly inside the open view square, some on its edge, some anywhere.
	function automatic logic signed [31:0] pick_coord();
		longint l;
		longint off;
		int p;
		l = longint'(m_half_width);
		p = $urandom_range(0, 99);
		if (p < 75 && l > 0) begin
			off = longint'({$urandom, $urandom} % (2 * l - 1));
			return 32'(-(l - 1) + off);
		end
		if (p < 87) begin
			case ($urandom_range(0, 3))
				0: return 32'(l);
				1: return 32'(-l);
				2: return 32'(l - 1);
				default: return 32'(-(l - 1));
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic signed [19:0] pick_index();
		case ($urandom_range(0, 9))
			0: return -20'sd1;
			1: return 20'sd0;
			2: return 20'(19'h7FFFF);
			3: return 20'($urandom_range(1, 600));
			default: return 20'($urandom);
		endcase
	endfunction

	// Present one star, wait for the transfer, then record its pixel writes.
	task automatic send_star(input star_row_t s);
		int gap;
		in_valid <= 1'b1;
		pos_x <= s.x;
		pos_y <= s.y;
		pos_z <= s.z;
		star_index <= s.idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		splat_star(s.x, s.y, s.z, s.idx, s.has_gray, s.typed_gray);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(input int count);
		star_row_t s;
		for (int k = 0; k < count; k++) begin
			s.x = pick_coord();
			s.y = pick_coord();
			s.z = pick_coord();
			s.idx = pick_index();
			s.has_gray = 1'b0;
			s.typed_gray = '0;
			send_star(s);
		end
	endtask

	// Receiver stalls with random lengths, plus stretches of steady readiness.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < 25) begin
			out_ready <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each result transfer with the oldest expected pixel write.
	always @(posedge clk) begin
		pixel_write_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pixel_q.size() == 0) begin
				$error("unexpected pixel write x=%0d y=%0d", pixel_x, pixel_y);
				fail_count++;
			end else begin
				e = pixel_q.pop_front();
				if (pixel_x !== e.px) begin
					$error("pixel_x expected %0d actual %0d", e.px, pixel_x);
					fail_count++;
				end
				if (pixel_y !== e.py) begin
					$error("pixel_y expected %0d actual %0d", e.py, pixel_y);
					fail_count++;
				end
				if (gray_level !== e.gray) begin
					$error("gray_level expected %0d actual %0d", e.gray, gray_level);
					fail_count++;
				end
				if (last_pixel !== e.last) begin
					$error("last_pixel expected %0d actual %0d", e.last, last_pixel);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		fail_count = 0;
		idle_cycles = 0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		star_index = '0;
		m_half_width = 31'd131072;
		m_image_size = 11'd256;
		m_point_size = 3'd3;
		m_axis = pds_pkg::AXIS_Z;
		m_color_low = 8'd10;
		m_color_high = 8'd255;

		// Directed stars under the reset settings (half-width 2.0, 256 pixels, along z).
		directed_stars[0]  = '{32'sd0, 32'sd0, 32'sd0, 20'sd0, 1'b1, pds_pkg::WhiteGray};
		directed_stars[1]  = '{32'sd0, 32'sd0, 32'sd0, -20'sd1, 1'b1, pds_pkg::WhiteGray};
		directed_stars[2]  = '{32'sd65536, -32'sd65536, 32'sd7, 20'sd1, 1'b0, '0};
		directed_stars[3]  = '{32'sd1000, 32'sd2000, 32'sd0, 20'sd245, 1'b0, '0};
		directed_stars[4]  = '{32'sd1000, 32'sd2000, 32'sd0, 20'sd244, 1'b0, '0};
		directed_stars[5]  = '{32'sd0, 32'sd0, 32'sd0, 20'sd524287, 1'b0, '0};
		directed_stars[6]  = '{-32'sd131071, 32'sd131071, 32'sd0, 20'sd0, 1'b1,
			pds_pkg::WhiteGray};
		directed_stars[7]  = '{32'sd131071, -32'sd131071, 32'sd0, -20'sd1, 1'b1,
			pds_pkg::WhiteGray};
		directed_stars[8]  = '{32'sd131072, 32'sd0, 32'sd0, 20'sd5, 1'b0, '0};
		directed_stars[9]  = '{-32'sd131072, 32'sd0, 32'sd0, 20'sd5, 1'b0, '0};
		directed_stars[10] = '{32'sh7FFFFFFF, 32'sd0, 32'sd0, 20'sd5, 1'b0, '0};
		directed_stars[11] = '{32'sd0, 32'sh80000000, 32'sd0, 20'sd5, 1'b0, '0};
		directed_stars[12] = '{32'sd0, 32'sd0, 32'sh80000000, 20'sd0, 1'b1,
			pds_pkg::WhiteGray};
		directed_stars[13] = '{32'sd0, 32'sd0, 32'sh7FFFFFFF, 20'sd9, 1'b0, '0};

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_stars[k]) send_star(directed_stars[k]);
		send_random(40);

		// Smallest view, smallest image, largest disc, along x.
		load_settings(31'd1, 16, 7, pds_pkg::AXIS_X, 0, 255);
		send_random(40);
		// Widest view, largest image, span below zero, along y.
		load_settings(31'h7FFFFFFF, 1024, 5, pds_pkg::AXIS_Y, 255, 1);
		send_random(50);
		// Image size above the maximum and axis code zero; unknown indexes are ignored.
		load_settings(31'd6553600, 2047, 4, pds_pkg::AXIS_NONE, 0, 1);
		write_reg(pds_pkg::reg_idx_t'(3'd6), 31'($urandom));
		write_reg(pds_pkg::reg_idx_t'(3'd7), 31'($urandom));
		send_random(50);
		// Zero half-width: nothing is visible.
		load_settings(31'd0, 256, 2, pds_pkg::AXIS_Z, 10, 255);
		send_random(15);
		// Zero image size: nothing is drawn.
		load_settings(31'd1048576, 0, 3, pds_pkg::AXIS_Z, 10, 255);
		send_random(15);
		// Zero color_high saturates the gray level of stars with a positive index.
		load_settings(31'd1048576, 17, 6, pds_pkg::AXIS_X, 200, 0);
		send_random(50);
		// Single-pixel stars.
		load_settings(31'd12345678, 1000, 0, pds_pkg::AXIS_Y, 5, 100);
		send_random(60);
		// Small image with the largest disc, heavy clipping.
		load_settings(31'd196608, 16, 7, pds_pkg::AXIS_Z, 0, 255);
		send_random(60);

		in_valid <= 1'b0;
		wait (pixel_q.size() == 0);
		repeat (SettleCycles) @(posedge clk);
		if (fail_count == 0 && pixel_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[point_disc_splatter_core.f]
hdl/pds_pkg.sv
hdl/pds_div.sv
hdl/pds_front.sv
hdl/pds_fifo.sv
hdl/pds_back.sv
hdl/point_disc_splatter_core.sv
verif/testbench.sv
